FILE: hw/rtl/ktls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the keyframe track linear sampler.
// Used by the controller, the datapath and the top level.
package ktls_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int NUM_W     = 48;   // |d| shifted up by 16 fraction bits
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int CHUNK_W   = 16;
  localparam int NUM_CHUNK = NUM_W / CHUNK_W;
  localparam int ACC_W     = 32 + NUM_W;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_ZERO_LEN = 2'd3
  } stat_e;

  typedef struct packed {
    logic start;
    logic app_wr;
    logic clr;
    logic set_full;
    logic set_empty;
    logic rd_t_idx;
    logic idx_inc;
    logic rd_seg;
    logic rd_v1;
    logic cap_v1;
    logic set_zl;
    logic rd_last;
    logic cap_last;
    logic div_init;
    logic div_step;
    logic mul_step;
    logic mul_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       count_zero;
    logic       count_full;
    logic       idx_end;
    logic       idx_next_end;
    logic       t_lt;
    logic       zero_len;
    logic       div_last;
    logic       chunk_last;
    logic       comp_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/ktls_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command words and result words.
// Depend on nothing but the field widths of the sampler.
interface ktls_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [31:0]       time_value;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;

  modport source (output valid, cmd, time_value, value_x, value_y, value_z, input ready);
  modport sink   (input valid, cmd, time_value, value_x, value_y, value_z, output ready);
endinterface

interface ktls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

FILE: hw/rtl/ktls_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the sampler: sequences search, divide and multiply.
// Depends on ktls_pkg for the command and status structs.
module ktls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ktls_pkg::dp_stat_t stat_i,
  output ktls_pkg::dp_cmd_t  cmd_o
);
  import ktls_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_RD_T     = 4'd2;
  localparam logic [3:0] S_CMP      = 4'd3;
  localparam logic [3:0] S_RD_V1    = 4'd4;
  localparam logic [3:0] S_CAP_V1   = 4'd5;
  localparam logic [3:0] S_CHK      = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;
  localparam logic [3:0] S_RD_LAST  = 4'd10;
  localparam logic [3:0] S_CAP_LAST = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          CMD_APPEND: begin
            if (stat_i.count_full) cmd_o.set_full = 1'b1;
            else cmd_o.app_wr = 1'b1;
          end
          CMD_CLEAR: cmd_o.clr = 1'b1;
          CMD_SAMPLE: begin
            if (stat_i.count_zero) cmd_o.set_empty = 1'b1;
            else if (stat_i.idx_end) state_d = S_RD_LAST;
            else state_d = S_RD_T;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD_T: begin
        cmd_o.rd_t_idx = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        if (stat_i.t_lt) begin
          cmd_o.rd_seg = 1'b1;
          state_d      = S_RD_V1;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.idx_next_end ? S_RD_LAST : S_RD_T;
        end
      end
      S_RD_V1: begin
        cmd_o.rd_v1 = 1'b1;
        state_d     = S_CAP_V1;
      end
      S_CAP_V1: begin
        cmd_o.cap_v1 = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        if (stat_i.zero_len) begin
          cmd_o.set_zl = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.chunk_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.mul_fin = 1'b1;
        state_d       = stat_i.comp_last ? S_DONE : S_MUL;
      end
      S_RD_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_CAP_LAST;
      end
      S_CAP_LAST: begin
        cmd_o.cap_last = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // The result word waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/ktls_dp.sv
`timescale 1ns / 1ps
// Datapath of the sampler: key memories, search index, radix-2 divider,
// chunked multiplier and output register. Depends on ktls_pkg.
module ktls_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ktls_pkg::dp_cmd_t  cmd_i,
  output ktls_pkg::dp_stat_t stat_o,
  input  logic [1:0]         cmd_code_i,
  input  logic [31:0]        time_value_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [1:0]         status_o
);
  import ktls_pkg::*;

  logic [31:0] times_mem [MAX_KEYS];
  logic [95:0] vals_mem  [MAX_KEYS];

  logic [1:0]         cmd_q;
  logic [31:0]        tv_q;
  logic [95:0]        vin_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   idx_q;
  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W-1:0]   last_idx;
  logic [31:0]        t_rd_q, t0_q, t1_q, den_q;
  logic [95:0]        v_rd_q, v0_q, v1_q;
  logic [31:0]        res_q [3];
  logic [1:0]         stat_q;
  logic [31:0]        rem_q;
  logic [NUM_W-1:0]   num_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic               dneg_q;
  logic [1:0]         chunk_q, comp_q;
  logic [ACC_W-1:0]   acc_q;
  logic [31:0]        out_x_q, out_y_q, out_z_q;
  logic [1:0]         out_stat_q;

  logic [KEY_AW-1:0]  t_addr, v_addr;
  logic               t_rd_en, v_rd_en;
  logic [32:0]        d_full, d_neg;
  logic [31:0]        d_mag;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [31:0]        s_c, e_c, ad;
  logic [32:0]        delta, delta_neg;
  logic [CHUNK_W-1:0] chunk;
  logic [47:0]        prod;
  logic [ACC_W-1:0]   prod_sh;
  logic [63:0]        mag;
  logic               mneg;
  logic signed [34:0] sum;
  logic [31:0]        lerp_res;

  function automatic logic [31:0] sel32(input logic [95:0] v, input logic [1:0] k);
    logic [31:0] r;
    case (k)
      2'd1:    r = v[63:32];
      2'd2:    r = v[95:64];
      default: r = v[31:0];
    endcase
    return r;
  endfunction

  assign idx_m1   = idx_q - CNT_W'(1);
  assign last_idx = count_q - CNT_W'(1);

  always_comb begin
    t_addr  = cmd_i.rd_seg ? idx_m1[KEY_AW-1:0] : idx_q[KEY_AW-1:0];
    t_rd_en = cmd_i.rd_t_idx | cmd_i.rd_seg;
    if (cmd_i.rd_seg) v_addr = idx_m1[KEY_AW-1:0];
    else if (cmd_i.rd_v1) v_addr = idx_q[KEY_AW-1:0];
    else v_addr = last_idx[KEY_AW-1:0];
    v_rd_en = cmd_i.rd_seg | cmd_i.rd_v1 | cmd_i.rd_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_wr) begin
      times_mem[count_q[KEY_AW-1:0]] <= tv_q;
      vals_mem[count_q[KEY_AW-1:0]]  <= vin_q;
    end
    if (t_rd_en) t_rd_q <= times_mem[t_addr];
    if (v_rd_en) v_rd_q <= vals_mem[v_addr];
  end

  // Divider and multiplier arithmetic.
  always_comb begin
    d_full = {1'b0, tv_q} - {1'b0, t0_q};
    d_neg  = -d_full;
    d_mag  = d_full[32] ? d_neg[31:0] : d_full[31:0];
    div_sh = {rem_q, num_q[NUM_W-1]};
    div_ge = div_sh >= {1'b0, den_q};

    s_c       = sel32(v0_q, comp_q);
    e_c       = sel32(v1_q, comp_q);
    delta     = {e_c[31], e_c} - {s_c[31], s_c};
    delta_neg = -delta;
    ad        = delta[32] ? delta_neg[31:0] : delta[31:0];
    case (chunk_q)
      2'd1:    chunk = num_q[31:16];
      2'd2:    chunk = num_q[47:32];
      default: chunk = num_q[15:0];
    endcase
    prod = {16'b0, ad} * {32'b0, chunk};
    case (chunk_q)
      2'd1:    prod_sh = {16'b0, prod, 16'b0};
      2'd2:    prod_sh = {prod, 32'b0};
      default: prod_sh = {32'b0, prod};
    endcase

    mag  = acc_q[ACC_W-1:16];
    mneg = delta[32] ^ dneg_q;
    sum  = mneg ? ($signed({{3{s_c[31]}}, s_c}) - $signed({2'b0, mag[32:0]}))
                : ($signed({{3{s_c[31]}}, s_c}) + $signed({2'b0, mag[32:0]}));
    if (|mag[63:33]) lerp_res = mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (sum > 35'sd2147483647) lerp_res = 32'h7FFF_FFFF;
    else if (sum < -35'sd2147483648) lerp_res = 32'h8000_0000;
    else lerp_res = sum[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      div_cnt_q <= '0;
      chunk_q   <= '0;
      comp_q    <= '0;
    end else begin
      if (cmd_i.start) idx_q <= CNT_W'(1);
      else if (cmd_i.idx_inc) idx_q <= idx_q + CNT_W'(1);
      if (cmd_i.app_wr) count_q <= count_q + CNT_W'(1);
      else if (cmd_i.clr) count_q <= '0;
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
        chunk_q   <= '0;
        comp_q    <= '0;
      end else begin
        if (cmd_i.div_step) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
        if (cmd_i.mul_step) chunk_q <= (chunk_q == 2'(NUM_CHUNK - 1)) ? 2'd0 : chunk_q + 2'd1;
        if (cmd_i.mul_fin) comp_q <= comp_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q    <= cmd_code_i;
      tv_q     <= time_value_i;
      vin_q    <= {value_z_i, value_y_i, value_x_i};
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
      stat_q   <= STAT_OK;
    end
    if (cmd_i.set_full)  stat_q <= STAT_FULL;
    if (cmd_i.set_empty) stat_q <= STAT_EMPTY;
    if (cmd_i.rd_seg) t1_q <= t_rd_q;
    if (cmd_i.rd_v1) begin
      t0_q <= t_rd_q;
      v0_q <= v_rd_q;
    end
    if (cmd_i.cap_v1) v1_q <= v_rd_q;
    if (cmd_i.set_zl) begin
      stat_q   <= STAT_ZERO_LEN;
      res_q[0] <= v0_q[31:0];
      res_q[1] <= v0_q[63:32];
      res_q[2] <= v0_q[95:64];
    end
    if (cmd_i.cap_last) begin
      res_q[0] <= v_rd_q[31:0];
      res_q[1] <= v_rd_q[63:32];
      res_q[2] <= v_rd_q[95:64];
    end
    if (cmd_i.div_init) begin
      den_q  <= t1_q - t0_q;
      dneg_q <= d_full[32];
      num_q  <= {d_mag, 16'b0};
      rem_q  <= '0;
      acc_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? 32'(div_sh - {1'b0, den_q}) : div_sh[31:0];
      num_q <= {num_q[NUM_W-2:0], div_ge};
    end
    if (cmd_i.mul_step) acc_q <= acc_q + prod_sh;
    if (cmd_i.mul_fin) begin
      res_q[comp_q] <= lerp_res;
      acc_q         <= '0;
    end
    if (cmd_i.out_load) begin
      out_x_q    <= res_q[0];
      out_y_q    <= res_q[1];
      out_z_q    <= res_q[2];
      out_stat_q <= stat_q;
    end
  end

  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.count_zero   = count_q == '0;
    stat_o.count_full   = count_q >= CNT_W'(MAX_KEYS);
    stat_o.idx_end      = idx_q == count_q;
    stat_o.idx_next_end = (idx_q + CNT_W'(1)) == count_q;
    stat_o.t_lt         = tv_q < t_rd_q;
    stat_o.zero_len     = t1_q <= t0_q;
    stat_o.div_last     = div_cnt_q == DIV_CNT_W'(NUM_W - 1);
    stat_o.chunk_last   = chunk_q == 2'(NUM_CHUNK - 1);
    stat_o.comp_last    = comp_q == 2'd2;
  end

  assign out_x_o  = out_x_q;
  assign out_y_o  = out_y_q;
  assign out_z_o  = out_z_q;
  assign status_o = out_stat_q;

endmodule

FILE: hw/rtl/keyframe_track_linear_sampler_top.sv
`timescale 1ns / 1ps
// Keyframe track linear sampler. A command word arrives on in_if: append a
// keyframe, clear the track, or sample the track at a time. Every command
// word yields exactly one result word on out_if, holding the interpolated
// vector (zero for non-sample commands) and a status code.
// One command is worked on at a time. Append, clear, an unused code and a
// sample of an empty track go from the decode state straight to the result. A
// sample walks the stored key times one key at a time, reading each through the
// time memory read port and comparing it, then a 48-step radix-2 divider forms
// the segment fraction and a 32x16 multiplier takes it in 16-bit chunks per
// component. A zero-length segment or a time past the last key skips the
// divider and multiplier. The input is ready again in the cycle after the
// result is loaded.
// The result sits in an output register; the next command is accepted while
// it waits, and a following result holds until the receiver takes the first.
// Reset empties the track; key memories need no clearing pass.
// Depends on ktls_pkg, ktls_if, ktls_ctrl and ktls_dp.
module keyframe_track_linear_sampler_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  ktls_in_if.sink    in_if,
  ktls_out_if.source out_if
);
  import ktls_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ktls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  ktls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .cmd_code_i   (in_if.cmd),
    .time_value_i (in_if.time_value),
    .value_x_i    (in_if.value_x),
    .value_y_i    (in_if.value_y),
    .value_z_i    (in_if.value_z),
    .out_x_o      (out_if.out_x),
    .out_y_o      (out_if.out_y),
    .out_z_o      (out_if.out_z),
    .status_o     (out_if.status)
  );

endmodule

FILE: tb/sv/tb_keyframe_track_linear_sampler_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the keyframe track linear sampler: a directed table,
// then random append/clear/sample words, checked against an in-bench predictor.
// Depends on ktls_pkg, ktls_if and keyframe_track_linear_sampler_top.
module tb_keyframe_track_linear_sampler_top;
  import ktls_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] tv;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        known;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic [1:0]  est;
  } row_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ktls_in_if  in_if ();
  ktls_out_if out_if ();

  keyframe_track_linear_sampler_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the track.
  logic [31:0] trk_time [MAX_KEYS];
  logic [31:0] trk_val  [MAX_KEYS][3];
  int unsigned trk_count;

  sample_t expected_q[$];
  int     fails;
  int     send_idle_pct;
  int     recv_idle_pct;
  logic   hold_off;
  longint cycles;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Start plus the scaled difference, using 128-bit arithmetic for exactness.
  function automatic logic [31:0] blend(logic [31:0] s, logic [31:0] e, longint tq);
    longint sv;
    longint dv;
    logic signed [127:0] p;
    logic signed [127:0] q;
    logic signed [127:0] r;
    sv = longint'(signed'(s));
    dv = longint'(signed'(e)) - sv;
    if (dv == 0 || tq == 0) return clamp32(sv);
    p = 128'(signed'(dv)) * 128'(signed'(tq));
    q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
    r = q + 128'(signed'(sv));
    if (r > 128'sd2147483647) return 32'h7fffffff;
    if (r < -128'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  function automatic sample_t track_step(logic [1:0] cmd, logic [31:0] tv,
                                         logic [31:0] vx, logic [31:0] vy,
                                         logic [31:0] vz);
    sample_t r;
    int seg;
    longint d;
    longint den;
    longint tq;
    r = '{x: '0, y: '0, z: '0, st: STAT_OK};
    seg = -1;
    case (cmd)
      CMD_APPEND: begin
        if (trk_count >= MAX_KEYS) begin
          r.st = STAT_FULL;
        end else begin
          trk_time[trk_count] = tv;
          trk_val[trk_count][0] = vx;
          trk_val[trk_count][1] = vy;
          trk_val[trk_count][2] = vz;
          trk_count++;
        end
      end
      CMD_CLEAR: trk_count = 0;
      CMD_SAMPLE: begin
        if (trk_count == 0) begin
          r.st = STAT_EMPTY;
        end else begin
          for (int i = 0; i + 1 < trk_count; i++) begin
            if (seg < 0 && tv < trk_time[i + 1]) seg = i;
          end
          if (seg < 0) begin
            r.x = trk_val[trk_count - 1][0];
            r.y = trk_val[trk_count - 1][1];
            r.z = trk_val[trk_count - 1][2];
          end else if (trk_time[seg + 1] <= trk_time[seg]) begin
            r.st = STAT_ZERO_LEN;
            r.x = trk_val[seg][0];
            r.y = trk_val[seg][1];
            r.z = trk_val[seg][2];
          end else begin
            d = longint'(tv) - longint'(trk_time[seg]);
            den = longint'(trk_time[seg + 1]) - longint'(trk_time[seg]);
            tq = (d * 65536) / den;
            r.x = blend(trk_val[seg][0], trk_val[seg + 1][0], tq);
            r.y = blend(trk_val[seg][1], trk_val[seg + 1][1], tq);
            r.z = blend(trk_val[seg][2], trk_val[seg + 1][2], tq);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [31:0] tv, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.time_value <= tv;
    in_if.value_x    <= vx;
    in_if.value_y    <= vy;
    in_if.value_z    <= vz;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(track_step(cmd, tv, vx, vy, vz));
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(131072)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  // Mostly small ascending tracks with random values, some noise words.
  task automatic random_track();
    int n;
    logic [31:0] t;
    logic [31:0] last;
    n = ($urandom_range(19) == 0) ? MAX_KEYS + 2 : $urandom_range(1, 6);
    send_word(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
    t = $urandom_range(1000000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(14) == 0) t = $urandom();
      send_word(CMD_APPEND, t, rand_val(), rand_val(), rand_val());
      last = t;
      t = t + (($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 400000)));
    end
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(3) == 0) t = $urandom();
      else t = last - 32'($urandom_range(400000 * n + 300000));
      send_word(($urandom_range(24) == 0) ? 2'd3 : CMD_SAMPLE, t, $urandom(), $urandom(),
                $urandom());
    end
  endtask

  // Receiver with random stalls and a long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    sample_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.out_x !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_if.out_x); fails++;
        end
        if (out_if.out_y !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_if.out_y); fails++;
        end
        if (out_if.out_z !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_if.out_z); fails++;
        end
        if (out_if.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_if.status); fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  row_t dir_tab[$];
  int   dir_hits;

  initial begin
    row_t rw;
    sample_t got;
    fails = 0;
    cycles = 0;
    hold_off = 1'b0;
    trk_count = 0;
    send_idle_pct = 19;
    recv_idle_pct = 46;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_CLEAR;
    in_if.time_value = '0;
    in_if.value_x = '0;
    in_if.value_y = '0;
    in_if.value_z = '0;
    dir_hits = 0;
    // Directed: empty, unused code, extremes, repeated key times, extrapolation.
    dir_tab = '{
      '{CMD_SAMPLE, 32'h0, 0, 0, 0, 1, 0, 0, 0, STAT_EMPTY},
      '{2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 0, 0, 0, STAT_OK},
      '{CMD_APPEND, 32'h10000, 32'h7fffffff, 32'h80000000, 32'h0, 1, 0, 0, 0, STAT_OK},
      '{CMD_SAMPLE, 32'h0, 0, 0, 0, 1, 32'h7fffffff, 32'h80000000, 0, STAT_OK},
      '{CMD_APPEND, 32'h20000, 32'h80000000, 32'h7fffffff, 32'h10000, 1, 0, 0, 0, STAT_OK},
      '{CMD_SAMPLE, 32'h18000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_SAMPLE, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_SAMPLE, 32'hffffffff, 0, 0, 0, 1, 32'h80000000, 32'h7fffffff, 32'h10000,
        STAT_OK},
      '{CMD_APPEND, 32'h20000, 32'h5, 32'h6, 32'h7, 1, 0, 0, 0, STAT_OK},
      '{CMD_APPEND, 32'h30000, 32'h9, 32'h9, 32'h9, 1, 0, 0, 0, STAT_OK},
      '{CMD_SAMPLE, 32'h20000, 0, 0, 0, 1, 32'h5, 32'h6, 32'h7, STAT_OK},
      '{CMD_APPEND, 32'h100, 32'h1, 32'h2, 32'h3, 1, 0, 0, 0, STAT_OK},
      '{CMD_SAMPLE, 32'h28000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_SAMPLE, 32'h30000, 0, 0, 0, 1, 32'h1, 32'h2, 32'h3, STAT_OK},
      '{CMD_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 0, 0, 0,
        STAT_OK},
      '{CMD_SAMPLE, 32'h5, 0, 0, 0, 1, 0, 0, 0, STAT_EMPTY}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      send_word(rw.cmd, rw.tv, rw.vx, rw.vy, rw.vz);
      got = expected_q[$];
      if (rw.known && (got.x !== rw.ex || got.y !== rw.ey || got.z !== rw.ez
                       || got.st !== rw.est)) begin
        $error("table row %0d disagrees with predictor", i);
        fails++;
      end
    end
    // Fill past capacity so appends are dropped, then sample the full track.
    for (int i = 0; i < MAX_KEYS + 1; i++)
      send_word(CMD_APPEND, 32'(i) << 20, $urandom(), $urandom(), $urandom());
    send_word(CMD_SAMPLE, 32'd63 << 20, 0, 0, 0);
    send_word(CMD_SAMPLE, 32'h3ff8000, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 46 : 0;
      recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 19 : 0;
      if (ph == 2) hold_off = 1'b1;
      for (int k = 0; k < 22; k++) random_track();
      wait_drained();
    end

    drop_valid();
    repeat (300) @(posedge clk_i);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    int n;
    wait (hold_off);
    n = 0;
    while (n < 2000) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

endmodule

FILE: filelist.f
hw/rtl/ktls_pkg.sv
hw/rtl/ktls_if.sv
hw/rtl/ktls_ctrl.sv
hw/rtl/ktls_dp.sv
hw/rtl/keyframe_track_linear_sampler_top.sv
tb/sv/tb_keyframe_track_linear_sampler_top.sv
